### rtl/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

  // command codes carried in tuser of the input channel
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // extra bits of the error term over the coordinate width
  localparam int ERR_EXTRA_BITS = 3;

  // rounds a bit count up to whole bytes
  function automatic int byte_pad(input int bits);
    byte_pad = ((bits + 7) / 8) * 8;
  endfunction

endpackage

### rtl/line_rasterizer_top.sv
`timescale 1ns / 1ps
// path: input stage register holds the beat, the result register its pixel
// throughput: one beat per cycle, loads and steps alike, and one pixel per cycle,
//   while the output is drained; the step engine updates the error with each pixel
// reset: synchronous active-low rst_n empties both stages and ends any active line
// no clearing pass; the block takes beats in the first cycle after reset

module line_rasterizer_top #(
  parameter int COORD_BITS = 11
) (
  input  logic clk,
  input  logic rst_n,
  // input channel
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tuser,   // command
  input  logic [lr_pkg::byte_pad(4*COORD_BITS)-1:0] in_tdata,
                           // start_x, start_y, end_x, end_y, zero pad
  // result channel
  output logic out_tvalid,
  input  logic out_tready,
  output logic out_tlast,  // last_pixel
  output logic [lr_pkg::byte_pad(2*COORD_BITS)-1:0] out_tdata
                           // pixel_x, pixel_y, zero pad
);

  localparam int CB       = COORD_BITS;
  localparam int OUT_BITS = lr_pkg::byte_pad(2*COORD_BITS);

  logic            item_valid;
  logic            item_take;
  logic            item_cmd;
  logic [4*CB-1:0] item_coords;
  logic [CB-1:0]   res_x;
  logic [CB-1:0]   res_y;

  // input register stage
  lr_in_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .up_cmd    (in_tuser),
    .up_coords (in_tdata[4*CB-1:0]),
    .dn_valid  (item_valid),
    .dn_take   (item_take),
    .dn_cmd    (item_cmd),
    .dn_coords (item_coords)
  );

  // line state and result register
  lr_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item_cmd    (item_cmd),
    .item_coords (item_coords),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_last    (out_tlast)
  );

  // pack result beat
  assign out_tdata = OUT_BITS'({res_y, res_x});

endmodule

### rtl/lr_in_stage.sv
`timescale 1ns / 1ps

module lr_in_stage #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // upstream side
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic                    up_cmd,
  input  logic [4*COORD_BITS-1:0] up_coords,   // start_x, start_y, end_x, end_y
  // downstream side
  output logic                    dn_valid,
  input  logic                    dn_take,
  output logic                    dn_cmd,
  output logic [4*COORD_BITS-1:0] dn_coords
);

  logic                    valid_r;
  logic                    valid_nxt;
  logic                    cmd_r;
  logic [4*COORD_BITS-1:0] coords_r;

  // free when empty or being drained this cycle
  assign up_ready  = !valid_r || dn_take;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cmd_r    <= up_cmd;
      coords_r <= up_coords;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_cmd    = cmd_r;
  assign dn_coords = coords_r;

endmodule

### rtl/lr_engine.sv
`timescale 1ns / 1ps

module lr_engine #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // registered item
  input  logic                    item_valid,
  output logic                    item_take,
  input  logic                    item_cmd,
  input  logic [4*COORD_BITS-1:0] item_coords,  // start_x, start_y, end_x, end_y
  // result register
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [COORD_BITS-1:0]   res_x,
  output logic [COORD_BITS-1:0]   res_y,
  output logic                    res_last
);

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + lr_pkg::ERR_EXTRA_BITS;

  // line state
  logic                 busy_r, busy_nxt;
  logic [CB-1:0]        cur_x_r, cur_x_nxt;
  logic [CB-1:0]        cur_y_r, cur_y_nxt;
  logic [CB-1:0]        major_end_r, major_end_nxt;
  logic [CB-1:0]        delta_major_r, delta_major_nxt;
  logic [CB-1:0]        delta_minor_r, delta_minor_nxt;
  logic signed [EB-1:0] err_r, err_nxt;
  logic                 x_major_r, x_major_nxt;
  logic                 minor_dec_r, minor_dec_nxt;

  // result register
  logic          out_v_r, out_v_nxt;
  logic [CB-1:0] out_x_r, out_x_nxt;
  logic [CB-1:0] out_y_r, out_y_nxt;
  logic          out_last_r, out_last_nxt;

  // load-side terms
  logic [CB-1:0] sx, sy, ex, ey;
  logic [CB-1:0] dx, dy;
  logic          ld_x_major, ld_swap;
  logic [CB-1:0] x1, y1, x2, y2;
  logic [CB-1:0] ld_dmaj, ld_dmin;

  // step-side terms
  logic          fire;
  logic [CB-1:0] major_cur;
  logic          last;
  logic [CB-1:0] minor_cur, minor_moved;

  assign sx = item_coords[0*CB +: CB];
  assign sy = item_coords[1*CB +: CB];
  assign ex = item_coords[2*CB +: CB];
  assign ey = item_coords[3*CB +: CB];

  // result slot free when empty or taken this cycle
  assign item_take = !out_v_r || res_ready;
  assign fire      = item_valid && item_take;

  // endpoint ordering and deltas
  always_comb begin
    dx         = (sx > ex) ? (sx - ex) : (ex - sx);
    dy         = (sy > ey) ? (sy - ey) : (ey - sy);
    ld_x_major = (dy < dx);
    ld_swap    = ld_x_major ? (sx > ex) : (sy > ey);
    x1         = ld_swap ? ex : sx;
    y1         = ld_swap ? ey : sy;
    x2         = ld_swap ? sx : ex;
    y2         = ld_swap ? sy : ey;
    ld_dmaj    = ld_x_major ? dx : dy;
    ld_dmin    = ld_x_major ? dy : dx;
  end

  // step terms
  always_comb begin
    major_cur   = x_major_r ? cur_x_r : cur_y_r;
    last        = (major_cur == major_end_r);
    minor_cur   = x_major_r ? cur_y_r : cur_x_r;
    minor_moved = minor_dec_r ? (minor_cur - CB'(1)) : (minor_cur + CB'(1));
  end

  // next state and next result
  always_comb begin
    busy_nxt        = busy_r;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    major_end_nxt   = major_end_r;
    delta_major_nxt = delta_major_r;
    delta_minor_nxt = delta_minor_r;
    err_nxt         = err_r;
    x_major_nxt     = x_major_r;
    minor_dec_nxt   = minor_dec_r;
    out_v_nxt       = item_take ? 1'b0 : out_v_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_last_nxt    = out_last_r;

    if (fire) begin
      if (item_cmd == lr_pkg::CMD_LOAD) begin
        // new line replaces any line in progress
        busy_nxt        = 1'b1;
        x_major_nxt     = ld_x_major;
        major_end_nxt   = ld_x_major ? x2 : y2;
        delta_major_nxt = ld_dmaj;
        delta_minor_nxt = ld_dmin;
        minor_dec_nxt   = ld_x_major ? (y2 < y1) : (x2 < x1);
        cur_x_nxt       = x1;
        cur_y_nxt       = y1;
        err_nxt         = (signed'(EB'(ld_dmin)) <<< 1) - signed'(EB'(ld_dmaj));
      end else if (busy_r) begin
        // emit current pixel
        out_v_nxt    = 1'b1;
        out_x_nxt    = cur_x_r;
        out_y_nxt    = cur_y_r;
        out_last_nxt = last;
        if (last) begin
          busy_nxt = 1'b0;
        end else begin
          // advance major axis, maybe minor axis
          if (x_major_r) begin
            cur_x_nxt = cur_x_r + CB'(1);
          end else begin
            cur_y_nxt = cur_y_r + CB'(1);
          end
          if (!err_r[EB-1]) begin
            if (x_major_r) begin
              cur_y_nxt = minor_moved;
            end else begin
              cur_x_nxt = minor_moved;
            end
            err_nxt = err_r + (signed'(EB'(delta_minor_r)) <<< 1)
                      - (signed'(EB'(delta_major_r)) <<< 1);
          end else begin
            err_nxt = err_r + (signed'(EB'(delta_minor_r)) <<< 1);
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // line and result payload
  always_ff @(posedge clk) begin
    cur_x_r       <= cur_x_nxt;
    cur_y_r       <= cur_y_nxt;
    major_end_r   <= major_end_nxt;
    delta_major_r <= delta_major_nxt;
    delta_minor_r <= delta_minor_nxt;
    err_r         <= err_nxt;
    x_major_r     <= x_major_nxt;
    minor_dec_r   <= minor_dec_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign res_valid = out_v_r;
  assign res_x     = out_x_r;
  assign res_y     = out_y_r;
  assign res_last  = out_last_r;

endmodule
